// ----- hw/rtl/tcp_flow_port_classifier_assert.svh -----
// Assertion macros shared by the classifier RTL.
`ifndef TCP_FLOW_PORT_CLASSIFIER_ASSERT_SVH
`define TCP_FLOW_PORT_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TFPC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define TFPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/tfpc_pkg.sv -----
`timescale 1ns / 1ps

package tfpc_pkg;

   localparam int PORT_INDEX_W = 5;

   typedef enum logic [0:0] {
      CSR_SOURCE_ADDRESS      = 1'b0,
      CSR_DESTINATION_ADDRESS = 1'b1
   } csr_index_type;

   localparam logic [31:0] SOURCE_ADDRESS_RESET      = 32'hAC1B_9997;
   localparam logic [31:0] DESTINATION_ADDRESS_RESET = 32'h72D4_5010;

   localparam logic [7:0] ETHERTYPE_HI = 8'h08;
   localparam logic [7:0] ETHERTYPE_LO = 8'h00;
   localparam logic [7:0] IP_PROTO_TCP = 8'h06;
   localparam logic [6:0] BASE_HDR_LEN = 7'd34;

   localparam logic [15:0] POS_ETYPE_HI = 16'd12;
   localparam logic [15:0] POS_ETYPE_LO = 16'd13;
   localparam logic [15:0] POS_PROTO    = 16'd23;
   localparam logic [15:0] POS_SRC_0    = 16'd26;
   localparam logic [15:0] POS_SRC_1    = 16'd27;
   localparam logic [15:0] POS_SRC_2    = 16'd28;
   localparam logic [15:0] POS_SRC_3    = 16'd29;
   localparam logic [15:0] POS_DST_0    = 16'd30;
   localparam logic [15:0] POS_DST_1    = 16'd31;
   localparam logic [15:0] POS_DST_2    = 16'd32;
   localparam logic [15:0] POS_DST_3    = 16'd33;
   localparam logic [15:0] POS_PORT_HI  = 16'd36;
   localparam logic [15:0] POS_PORT_LO  = 16'd37;
   localparam logic [15:0] POS_OFFSET   = 16'd46;
   localparam logic [15:0] POS_MAX      = 16'hFFFF;

   typedef struct packed {
      logic        lookup;
      logic        clear;
      logic [15:0] port;
   } cam_req_type;

   typedef struct packed {
      logic                    new_port;
      logic                    table_full;
      logic [PORT_INDEX_W-1:0] port_index;
   } cam_rsp_type;

endpackage

// ----- hw/rtl/tfpc_port_cam.sv -----
`timescale 1ns / 1ps

`include "tcp_flow_port_classifier_assert.svh"

module tfpc_port_cam #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tfpc_pkg::cam_req_type cam_req,
   output tfpc_pkg::cam_rsp_type cam_rsp
);
   import tfpc_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   logic [15:0]      table_ff [TABLE_DEPTH];
   logic [CNT_W-1:0] entry_count_ff;
   logic [CNT_W-1:0] entry_count_in;

   logic [TABLE_DEPTH-1:0] hit_vec;
   logic                   hit;
   logic [IDX_W-1:0]       hit_idx;
   logic                   full;
   logic                   insert;
   logic [IDX_W-1:0]       index;
   logic [IDX_W+PORT_INDEX_W-1:0] index_ext;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_vec[i] = (CNT_W'(i) < entry_count_ff) && (table_ff[i] == cam_req.port);
      end
   end

   always_comb begin
      hit_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
      end
   end

   assign hit    = |hit_vec;
   assign full   = (entry_count_ff == DEPTH_CNT);
   assign insert = cam_req.lookup && !hit && !full;

   always_comb begin
      if (hit) begin
         index = hit_idx;
      end else if (!full) begin
         index = entry_count_ff[IDX_W-1:0];
      end else begin
         index = '0;
      end
   end

   assign index_ext          = {{PORT_INDEX_W{1'b0}}, index};
   assign cam_rsp.port_index = index_ext[PORT_INDEX_W-1:0];
   assign cam_rsp.new_port   = !hit && !full;
   assign cam_rsp.table_full = !hit && full;

   always_comb begin
      entry_count_in = entry_count_ff;
      if (cam_req.clear) begin
         entry_count_in = '0;
      end else if (insert) begin
         entry_count_in = entry_count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (insert) begin
         table_ff[entry_count_ff[IDX_W-1:0]] <= cam_req.port;
      end
   end

   `TFPC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, entry_count_ff <= DEPTH_CNT, "entry count past depth")
   `TFPC_ASSERT_NEXT(a_clear_empties, clock, reset, cam_req.clear, entry_count_ff == '0, "clear left entries")
   `TFPC_ASSERT_NEXT(a_insert_grows, clock, reset, insert, entry_count_ff == $past(entry_count_ff) + CNT_W'(1), "insert did not grow table")

endmodule

// ----- hw/rtl/tcp_flow_port_classifier.sv -----
`timescale 1ns / 1ps
// A frame's last byte passes the input register, then its result the result register.
// Throughput: one word per cycle unless stalled; lookup and append finish in that cycle.
// While a result waits on rsp_ready, bytes that end no frame still advance;
// a frame end waits in the input register until the result leaves; clears still advance.
// Reset (synchronous, active high): empty port table, frame state cleared,
// address registers back to their defaults. No clearing pass is needed.

`include "tcp_flow_port_classifier_assert.svh"

module tcp_flow_port_classifier #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  tfpc_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [7:0]             req_frame_byte,
   input  logic                   req_frame_end,
   input  logic [15:0]            req_frame_length,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_matched,
   output logic                   rsp_new_port,
   output logic [4:0]             rsp_port_index,
   output logic [15:0]            rsp_dst_port,
   output logic [15:0]            rsp_payload_length,
   output logic                   rsp_table_full
);
   import tfpc_pkg::*;

   logic [31:0] src_addr_ff;
   logic [31:0] dst_addr_ff;

   logic        s1_valid_ff;
   logic        s1_cmd_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_end_ff;
   logic [15:0] s1_length_ff;

   logic [15:0] pos_ff;
   logic        header_ok_ff;
   logic [15:0] port_ff;
   logic [7:0]  offset_ff;
   logic [15:0] port_in;
   logic [7:0]  offset_in;
   logic        byte_ok;

   logic        rsp_valid_ff;
   logic        matched_ff;
   logic        new_port_ff;
   logic [4:0]  port_index_ff;
   logic [15:0] dst_port_ff;
   logic [15:0] payload_ff;
   logic        table_full_ff;

   logic        s1_emits;
   logic        s1_advance;
   logic        frame_byte_go;
   logic        frame_match;
   logic [7:0]  offset_eff;
   logic [6:0]  sub_len;
   logic [15:0] payload_len;

   cam_req_type cam_req;
   cam_rsp_type cam_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_addr_ff <= SOURCE_ADDRESS_RESET;
         dst_addr_ff <= DESTINATION_ADDRESS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SOURCE_ADDRESS:      src_addr_ff <= csr_write_data;
            CSR_DESTINATION_ADDRESS: dst_addr_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign s1_emits      = s1_valid_ff && !s1_cmd_ff && s1_end_ff;
   assign s1_advance    = s1_valid_ff && (!s1_emits || !rsp_valid_ff || rsp_ready);
   assign req_ready     = !s1_valid_ff || s1_advance;
   assign frame_byte_go = s1_advance && !s1_cmd_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff    <= req_cmd;
         s1_byte_ff   <= req_frame_byte;
         s1_end_ff    <= req_frame_end;
         s1_length_ff <= req_frame_length;
      end
   end

   // header checks and field capture
   always_comb begin
      byte_ok   = 1'b1;
      port_in   = port_ff;
      offset_in = offset_ff;
      unique case (pos_ff)
         POS_ETYPE_HI: byte_ok = (s1_byte_ff == ETHERTYPE_HI);
         POS_ETYPE_LO: byte_ok = (s1_byte_ff == ETHERTYPE_LO);
         POS_PROTO:    byte_ok = (s1_byte_ff == IP_PROTO_TCP);
         POS_SRC_0:    byte_ok = (s1_byte_ff == src_addr_ff[31:24]);
         POS_SRC_1:    byte_ok = (s1_byte_ff == src_addr_ff[23:16]);
         POS_SRC_2:    byte_ok = (s1_byte_ff == src_addr_ff[15:8]);
         POS_SRC_3:    byte_ok = (s1_byte_ff == src_addr_ff[7:0]);
         POS_DST_0:    byte_ok = (s1_byte_ff == dst_addr_ff[31:24]);
         POS_DST_1:    byte_ok = (s1_byte_ff == dst_addr_ff[23:16]);
         POS_DST_2:    byte_ok = (s1_byte_ff == dst_addr_ff[15:8]);
         POS_DST_3:    byte_ok = (s1_byte_ff == dst_addr_ff[7:0]);
         POS_PORT_HI:  port_in = {s1_byte_ff, port_ff[7:0]};
         POS_PORT_LO:  port_in = {port_ff[15:8], s1_byte_ff};
         POS_OFFSET:   offset_in = s1_byte_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         header_ok_ff <= 1'b1;
         port_ff      <= '0;
         offset_ff    <= '0;
      end else if (frame_byte_go) begin
         if (s1_end_ff) begin
            pos_ff       <= '0;
            header_ok_ff <= 1'b1;
            port_ff      <= '0;
            offset_ff    <= '0;
         end else begin
            if (pos_ff != POS_MAX) begin
               pos_ff <= pos_ff + 16'd1;
            end
            header_ok_ff <= header_ok_ff && byte_ok;
            port_ff      <= port_in;
            offset_ff    <= offset_in;
         end
      end
   end

   assign frame_match = header_ok_ff && (pos_ff >= POS_OFFSET);
   assign offset_eff  = offset_in;
   assign sub_len     = {1'b0, offset_eff[7:4], 2'b00} + BASE_HDR_LEN;
   assign payload_len = (s1_length_ff > 16'(sub_len)) ? (s1_length_ff - 16'(sub_len)) : '0;

   assign cam_req.lookup = s1_advance && s1_emits && frame_match;
   assign cam_req.clear  = s1_advance && s1_cmd_ff;
   assign cam_req.port   = port_ff;

   tfpc_port_cam #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_port_cam (
      .clock   (clock),
      .reset   (reset),
      .cam_req (cam_req),
      .cam_rsp (cam_rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_emits) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_emits) begin
         matched_ff    <= frame_match;
         new_port_ff   <= frame_match && cam_rsp.new_port;
         port_index_ff <= frame_match ? cam_rsp.port_index : '0;
         dst_port_ff   <= frame_match ? port_ff : '0;
         payload_ff    <= frame_match ? payload_len : '0;
         table_full_ff <= frame_match && cam_rsp.table_full;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_matched        = matched_ff;
   assign rsp_new_port       = new_port_ff;
   assign rsp_port_index     = port_index_ff;
   assign rsp_dst_port       = dst_port_ff;
   assign rsp_payload_length = payload_ff;
   assign rsp_table_full     = table_full_ff;

   `TFPC_ASSERT_NOW(a_unmatched_zero, clock, reset, rsp_valid_ff && !matched_ff, (dst_port_ff == '0) && (payload_ff == '0) && !new_port_ff && !table_full_ff, "unmatched word has nonzero fields")
   `TFPC_ASSERT_NOW(a_new_or_full, clock, reset, rsp_valid_ff, !(new_port_ff && table_full_ff), "new port and full together")
   `TFPC_ASSERT_NEXT(a_frame_restart, clock, reset, frame_byte_go && s1_end_ff, (pos_ff == '0) && header_ok_ff, "frame state not restarted")

endmodule
